@@ rtl/tli_pkg.sv @@
`default_nettype none

package tli_pkg;

  // Default sizes of the stores.
  localparam int MAX_CELLS_DEF   = 256;
  localparam int PROG_DEPTH_DEF  = 4096;
  localparam int STACK_DEPTH_DEF = 64;

  // Configuration register file.
  localparam int          CFG_AW         = 3;
  localparam int          CFG_DW         = 32;
  localparam int          CELL_CNT_W     = 9;
  localparam logic [8:0]  CELL_COUNT_RST = 9'd10;
  localparam logic        REG_CELL_COUNT = 1'b0;

  // Request functions.
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_STEP  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_STEPPED = 3'd0;
  localparam logic [2:0] ST_BYTE    = 3'd1;
  localparam logic [2:0] ST_DECIMAL = 3'd2;
  localparam logic [2:0] ST_HALTED  = 3'd3;
  localparam logic [2:0] ST_ERROR   = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_BOUNDS   = 2'd0;
  localparam logic [1:0] ERR_VALUE    = 2'd1;
  localparam logic [1:0] ERR_SYNTAX   = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // Program characters.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;

  localparam logic [7:0] CELL_MAX = 8'd255;

endpackage

`default_nettype wire

@@ rtl/tli_if.sv @@
`default_nettype none

interface tli_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;
  logic [7:0] in_value;
  logic       in_bad;

  modport source (output valid, func, char_code, in_value, in_bad, input ready);
  modport sink   (input valid, func, char_code, in_value, in_bad, output ready);
endinterface

interface tli_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_value;
  logic [1:0] error_code;

  modport source (output valid, status, out_value, error_code, input ready);
  modport sink   (input valid, status, out_value, error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/tli_ram.sv @@
`default_nettype none

module tli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tli_cfg.sv @@
`default_nettype none

module tli_cfg #(
  parameter int MAX_CELLS = tli_pkg::MAX_CELLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tli_pkg::CFG_AW-1:0] paddr,
  input  wire logic [tli_pkg::CFG_DW-1:0] pwdata,
  output logic      [tli_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output logic [((tli_pkg::CELL_CNT_W > $clog2(MAX_CELLS + 1)) ?
                 tli_pkg::CELL_CNT_W : $clog2(MAX_CELLS + 1))-1:0] cell_limit
);

  localparam int NW = (tli_pkg::CELL_CNT_W > $clog2(MAX_CELLS + 1)) ?
                      tli_pkg::CELL_CNT_W : $clog2(MAX_CELLS + 1);

  logic [tli_pkg::CELL_CNT_W-1:0] cell_count_r;
  logic [tli_pkg::CELL_CNT_W-1:0] cell_count_nxt;
  logic                           sel_count;
  logic [NW-1:0]                  count_ext;

  assign pready    = 1'b1;
  assign sel_count = (paddr[tli_pkg::CFG_AW-1:2] == tli_pkg::REG_CELL_COUNT);

  always_comb begin
    cell_count_nxt = cell_count_r;
    if (psel && penable && pwrite && sel_count) begin
      cell_count_nxt = pwdata[tli_pkg::CELL_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= tli_pkg::CELL_COUNT_RST;
    end else begin
      cell_count_r <= cell_count_nxt;
    end
  end

  assign prdata = sel_count ? tli_pkg::CFG_DW'(cell_count_r) : '0;

  // The usable cell count is clamped to 1..MAX_CELLS.
  assign count_ext = NW'(cell_count_r);

  always_comb begin
    if (count_ext == '0) begin
      cell_limit = NW'(1);
    end else if (count_ext > NW'(MAX_CELLS)) begin
      cell_limit = NW'(MAX_CELLS);
    end else begin
      cell_limit = count_ext;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tape_language_interpreter_core.sv @@
`default_nettype none

// Channel  Dir  Handshake      Payload
// in_ch    in   valid / ready  func, char_code, in_value, in_bad
// out_ch   out  valid / ready  status, out_value, error_code
// cfg      in   APB write/read cell_count at byte address 0
//
// Load, clear and ignored requests are handled in S_IDLE, as is a step on a
// stopped machine or at the end of the program. Any other step first reads
// the program, tape and loop stack memories, then updates the cell, pointer
// or stack in S_EXEC. A '#' then walks the rest of its line in S_SCAN, one
// character at a time, through the single program memory read port.
// rst_n clears all control state and the tape valid flags; no clearing pass.
// A result waits in the output register while the next request is taken; a
// further result then holds the block until the output register frees up.

module tape_language_interpreter_core #(
  parameter int MAX_CELLS   = tli_pkg::MAX_CELLS_DEF,
  parameter int PROG_DEPTH  = tli_pkg::PROG_DEPTH_DEF,
  parameter int STACK_DEPTH = tli_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tli_in_if.sink                          in_ch,
  tli_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tli_pkg::CFG_AW-1:0] paddr,
  input  wire logic [tli_pkg::CFG_DW-1:0] pwdata,
  output logic      [tli_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);

  localparam int PC_W = $clog2(PROG_DEPTH + 1);
  localparam int PA_W = $clog2(PROG_DEPTH);
  localparam int DP_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SD_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int NW   = (tli_pkg::CELL_CNT_W > $clog2(MAX_CELLS + 1)) ?
                        tli_pkg::CELL_CNT_W : $clog2(MAX_CELLS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] len_r, len_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [DP_W-1:0] dp_r, dp_nxt;
  logic [SD_W-1:0] ld_r, ld_nxt;
  logic [PC_W-1:0] skip_r, skip_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic            stopped_r, stopped_nxt;
  logic [MAX_CELLS-1:0] tape_vld_r, tape_vld_nxt;
  logic            cell_vld_r, cell_vld_nxt;
  logic [7:0]      val_r, val_nxt;
  logic            bad_r, bad_nxt;
  logic [PC_W-1:0] k_r, k_nxt;
  logic [2:0]      res_st_r, res_st_nxt;
  logic [7:0]      res_val_r, res_val_nxt;
  logic [1:0]      res_err_r, res_err_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_st_r, out_st_nxt;
  logic [7:0]      out_val_r, out_val_nxt;
  logic [1:0]      out_err_r, out_err_nxt;

  logic [NW-1:0]   cell_limit;

  logic            prog_we, prog_re;
  logic [PA_W-1:0] prog_waddr, prog_raddr;
  logic [7:0]      prog_wdata, prog_rdata;
  logic            tape_we, tape_re;
  logic [7:0]      tape_wdata, tape_rdata;
  logic            stk_we, stk_re;
  logic [SA_W-1:0] stk_waddr, stk_raddr;
  logic [PA_W-1:0] stk_wdata, stk_rdata;

  logic            slot_free;
  logic [SD_W-1:0] ld_m1;
  logic [7:0]      c;
  logic [7:0]      cur_cell;
  logic [NW:0]     dp_p2;
  logic            e_req;
  logic [2:0]      e_st;
  logic [7:0]      e_val;
  logic [1:0]      e_err;
  logic            adv;
  logic            scan_req;
  logic [PC_W-1:0] scan_k;
  logic            fin_req;
  logic [PC_W-1:0] fin_k;
  logic [PC_W:0]   fin_kp1;

  tli_cfg #(.MAX_CELLS(MAX_CELLS)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cell_limit (cell_limit)
  );

  tli_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .re    (prog_re),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  tli_ram #(.WIDTH(8), .DEPTH(MAX_CELLS)) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (dp_r),
    .wdata (tape_wdata),
    .re    (tape_re),
    .raddr (dp_r),
    .rdata (tape_rdata)
  );

  tli_ram #(.WIDTH(PA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.out_value  = out_val_r;
  assign out_ch.error_code = out_err_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign ld_m1     = ld_r - SD_W'(1);
  assign c         = prog_rdata;
  assign cur_cell  = cell_vld_r ? tape_rdata : 8'd0;
  assign dp_p2     = (NW + 1)'(dp_r) + (NW + 1)'(2);

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    pc_nxt       = pc_r;
    dp_nxt       = dp_r;
    ld_nxt       = ld_r;
    skip_nxt     = skip_r;
    prev_nxt     = prev_r;
    stopped_nxt  = stopped_r;
    tape_vld_nxt = tape_vld_r;
    cell_vld_nxt = cell_vld_r;
    val_nxt      = val_r;
    bad_nxt      = bad_r;
    k_nxt        = k_r;
    res_st_nxt   = res_st_r;
    res_val_nxt  = res_val_r;
    res_err_nxt  = res_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_st_nxt   = out_st_r;
    out_val_nxt  = out_val_r;
    out_err_nxt  = out_err_r;

    prog_we    = 1'b0;
    prog_waddr = len_r[PA_W-1:0];
    prog_wdata = in_ch.char_code;
    prog_re    = 1'b0;
    prog_raddr = pc_r[PA_W-1:0];
    tape_we    = 1'b0;
    tape_re    = 1'b0;
    tape_wdata = val_r;
    stk_we     = 1'b0;
    stk_waddr  = ld_r[SA_W-1:0];
    stk_wdata  = pc_r[PA_W-1:0];
    stk_re     = 1'b0;
    stk_raddr  = ld_m1[SA_W-1:0];

    e_req    = 1'b0;
    e_st     = tli_pkg::ST_STEPPED;
    e_val    = 8'd0;
    e_err    = tli_pkg::ERR_BOUNDS;
    adv      = 1'b0;
    scan_req = 1'b0;
    scan_k   = k_r;
    fin_req  = 1'b0;
    fin_k    = k_r;
    fin_kp1  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.func)
            tli_pkg::FN_LOAD: begin
              if (len_r < PC_W'(PROG_DEPTH)) begin
                prog_we = 1'b1;
                len_nxt = len_r + PC_W'(1);
              end
            end
            tli_pkg::FN_CLEAR: begin
              len_nxt      = '0;
              pc_nxt       = '0;
              dp_nxt       = '0;
              ld_nxt       = '0;
              skip_nxt     = '0;
              prev_nxt     = '0;
              stopped_nxt  = 1'b0;
              tape_vld_nxt = '0;
            end
            tli_pkg::FN_STEP: begin
              if (stopped_r) begin
                e_req = 1'b1;
                e_st  = tli_pkg::ST_HALTED;
              end else if (pc_r >= len_r) begin
                stopped_nxt = 1'b1;
                e_req       = 1'b1;
                if (skip_r != '0) begin
                  e_st  = tli_pkg::ST_ERROR;
                  e_err = tli_pkg::ERR_SYNTAX;
                end else begin
                  e_st = tli_pkg::ST_HALTED;
                end
              end else begin
                prog_re      = 1'b1;
                tape_re      = 1'b1;
                stk_re       = 1'b1;
                cell_vld_nxt = tape_vld_r[dp_r];
                val_nxt      = in_ch.in_value;
                bad_nxt      = in_ch.in_bad;
                state_nxt    = S_EXEC;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_EXEC: begin
        if (c == tli_pkg::CH_HASH) begin
          scan_req = 1'b1;
          scan_k   = pc_r + PC_W'(1);
        end else if (skip_r != '0) begin
          if (c == tli_pkg::CH_LBRACK) begin
            skip_nxt = skip_r + PC_W'(1);
          end else if (c == tli_pkg::CH_RBRACK) begin
            skip_nxt = skip_r - PC_W'(1);
          end
          adv   = 1'b1;
          e_req = 1'b1;
        end else begin
          adv   = 1'b1;
          e_req = 1'b1;
          case (c)
            tli_pkg::CH_GT: begin
              if (dp_p2 > {1'b0, cell_limit}) begin
                adv = 1'b0;
                stopped_nxt = 1'b1;
                e_st  = tli_pkg::ST_ERROR;
                e_err = tli_pkg::ERR_BOUNDS;
              end else begin
                dp_nxt = dp_r + DP_W'(1);
              end
            end
            tli_pkg::CH_LT: begin
              if (dp_r == '0) begin
                adv = 1'b0;
                stopped_nxt = 1'b1;
                e_st  = tli_pkg::ST_ERROR;
                e_err = tli_pkg::ERR_BOUNDS;
              end else begin
                dp_nxt = dp_r - DP_W'(1);
              end
            end
            tli_pkg::CH_PLUS: begin
              if (cur_cell == tli_pkg::CELL_MAX) begin
                adv = 1'b0;
                stopped_nxt = 1'b1;
                e_st  = tli_pkg::ST_ERROR;
                e_err = tli_pkg::ERR_VALUE;
              end else begin
                tape_we    = 1'b1;
                tape_wdata = cur_cell + 8'd1;
                tape_vld_nxt[dp_r] = 1'b1;
              end
            end
            tli_pkg::CH_MINUS: begin
              if (cur_cell == 8'd0) begin
                adv = 1'b0;
                stopped_nxt = 1'b1;
                e_st  = tli_pkg::ST_ERROR;
                e_err = tli_pkg::ERR_VALUE;
              end else begin
                tape_we    = 1'b1;
                tape_wdata = cur_cell - 8'd1;
                tape_vld_nxt[dp_r] = 1'b1;
              end
            end
            tli_pkg::CH_DOT: begin
              e_st  = (prev_r == tli_pkg::CH_BSLASH) ? tli_pkg::ST_DECIMAL
                                                     : tli_pkg::ST_BYTE;
              e_val = cur_cell;
            end
            tli_pkg::CH_COMMA: begin
              if (bad_r) begin
                adv = 1'b0;
                stopped_nxt = 1'b1;
                e_st  = tli_pkg::ST_ERROR;
                e_err = tli_pkg::ERR_VALUE;
              end else begin
                tape_we    = 1'b1;
                tape_wdata = val_r;
                tape_vld_nxt[dp_r] = 1'b1;
              end
            end
            tli_pkg::CH_LBRACK: begin
              if (cur_cell == 8'd0) begin
                skip_nxt = PC_W'(1);
              end else if (ld_r >= SD_W'(STACK_DEPTH)) begin
                adv = 1'b0;
                stopped_nxt = 1'b1;
                e_st  = tli_pkg::ST_ERROR;
                e_err = tli_pkg::ERR_OVERFLOW;
              end else begin
                stk_we = 1'b1;
                ld_nxt = ld_r + SD_W'(1);
              end
            end
            tli_pkg::CH_RBRACK: begin
              if (ld_r == '0) begin
                adv = 1'b0;
                stopped_nxt = 1'b1;
                e_st  = tli_pkg::ST_ERROR;
                e_err = tli_pkg::ERR_SYNTAX;
              end else if (cur_cell != 8'd0) begin
                // Jump back to the character after the matching '['.
                adv      = 1'b0;
                pc_nxt   = PC_W'(stk_rdata) + PC_W'(1);
                prev_nxt = tli_pkg::CH_LBRACK;
              end else begin
                ld_nxt = ld_r - SD_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (c == tli_pkg::CH_NEWLINE) begin
          fin_req = 1'b1;
          fin_k   = k_r;
        end else begin
          scan_req = 1'b1;
          scan_k   = k_r + PC_W'(1);
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_val_nxt   = res_val_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      pc_nxt   = pc_r + PC_W'(1);
      prev_nxt = (c == tli_pkg::CH_NEWLINE) ? 8'd0 : c;
    end

    // The line scan reads one character a cycle until a newline or the end.
    if (scan_req) begin
      if (scan_k >= len_r) begin
        fin_req = 1'b1;
        fin_k   = scan_k;
      end else begin
        prog_re    = 1'b1;
        prog_raddr = scan_k[PA_W-1:0];
        k_nxt      = scan_k;
        state_nxt  = S_SCAN;
      end
    end

    if (fin_req) begin
      fin_kp1 = (PC_W + 1)'(fin_k) + (PC_W + 1)'(1);
      e_req   = 1'b1;
      if (fin_kp1 >= (PC_W + 1)'(len_r)) begin
        stopped_nxt = 1'b1;
        e_st        = tli_pkg::ST_HALTED;
      end else begin
        pc_nxt   = fin_kp1[PC_W-1:0];
        prev_nxt = 8'd0;
        e_st     = tli_pkg::ST_STEPPED;
      end
    end

    if (e_req) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_st_nxt    = e_st;
        out_val_nxt   = e_val;
        out_err_nxt   = e_err;
        state_nxt     = S_IDLE;
      end else begin
        res_st_nxt  = e_st;
        res_val_nxt = e_val;
        res_err_nxt = e_err;
        state_nxt   = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pc_r        <= '0;
      dp_r        <= '0;
      ld_r        <= '0;
      skip_r      <= '0;
      prev_r      <= '0;
      stopped_r   <= 1'b0;
      tape_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pc_r        <= pc_nxt;
      dp_r        <= dp_nxt;
      ld_r        <= ld_nxt;
      skip_r      <= skip_nxt;
      prev_r      <= prev_nxt;
      stopped_r   <= stopped_nxt;
      tape_vld_r  <= tape_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cell_vld_r <= cell_vld_nxt;
    val_r      <= val_nxt;
    bad_r      <= bad_nxt;
    k_r        <= k_nxt;
    res_st_r   <= res_st_nxt;
    res_val_r  <= res_val_nxt;
    res_err_r  <= res_err_nxt;
    out_st_r   <= out_st_nxt;
    out_val_r  <= out_val_nxt;
    out_err_r  <= out_err_nxt;
  end

endmodule

`default_nettype wire
